// ----- rtl/eska_pkg.sv -----
// ----------------------------------------------------------------------------
// eska_pkg
// Shared constants, codes and shape tables for the eye keyframe animator.
// ----------------------------------------------------------------------------
package eska_pkg;

	// default keyframe slot count
	localparam int FRAME_SLOTS_DEF = 3;

	// shape layout: nine values per eye, two eyes
	localparam int NPAR  = 9;
	localparam int NELEM = 2 * NPAR;

	// shape value positions
	localparam logic [3:0] P_CX = 4'd0;
	localparam logic [3:0] P_CY = 4'd1;
	localparam logic [3:0] P_W  = 4'd2;
	localparam logic [3:0] P_H  = 4'd3;
	localparam logic [3:0] P_R  = 4'd4;
	localparam logic [3:0] P_UA = 4'd5;
	localparam logic [3:0] P_LA = 4'd6;
	localparam logic [3:0] P_US = 4'd7;
	localparam logic [3:0] P_LS = 4'd8;

	// commands
	localparam logic [1:0] CMD_TICK   = 2'd0;
	localparam logic [1:0] CMD_EXPR   = 2'd1;
	localparam logic [1:0] CMD_ACTION = 2'd2;

	// actions, also used as script kinds, plus the expression transition
	localparam logic [1:0] ACT_BLINK  = 2'd0;
	localparam logic [1:0] ACT_WAKE   = 2'd1;
	localparam logic [1:0] ACT_SLEEP  = 2'd2;
	localparam logic [1:0] KIND_TRANS = 2'd3;

	// expressions
	localparam logic [2:0] EXPR_NEUTRAL  = 3'd0;
	localparam logic [2:0] EXPR_SMILE    = 3'd1;
	localparam logic [2:0] EXPR_HAPPY    = 3'd2;
	localparam logic [2:0] EXPR_ANGRY    = 3'd3;
	localparam logic [2:0] EXPR_SLEEPY   = 3'd4;
	localparam logic [2:0] EXPR_SURPRISE = 3'd5;
	localparam logic [2:0] EXPR_SAD      = 3'd6;
	localparam logic [2:0] EXPR_CURIOUS  = 3'd7;

	// amounts in 1/256 units
	localparam logic [8:0] AMT_FULL = 9'd256;
	localparam logic [8:0] AMT_TOL  = 9'd3;

	// closed lid values, Q8.8
	localparam logic signed [15:0] LID_HEIGHT = 16'sd512;
	localparam logic signed [15:0] LID_RADIUS = 16'sd256;

	// keyframe durations in ms
	localparam logic [9:0] DUR_BLINK0 = 10'd80;
	localparam logic [9:0] DUR_BLINK1 = 10'd100;
	localparam logic [9:0] DUR_WAKE0  = 10'd250;
	localparam logic [9:0] DUR_WAKE1  = 10'd150;
	localparam logic [9:0] DUR_WAKE2  = 10'd250;
	localparam logic [9:0] DUR_SLEEP0 = 10'd600;
	localparam logic [9:0] DUR_SLEEP1 = 10'd800;
	localparam logic [9:0] DUR_TRANS  = 10'd300;

	// neutral shape in whole pixels
	function automatic logic signed [7:0] base_px(input logic side, input logic [3:0] par);
		logic signed [7:0] v;
		v = 8'sd0;
		case (par)
			P_CX:    v = side ? 8'sd30 : -8'sd30;
			P_W:     v = 8'sd40;
			P_H:     v = 8'sd34;
			P_R:     v = 8'sd10;
			default: v = 8'sd0;
		endcase
		return v;
	endfunction

	// full-strength expression target in whole pixels
	function automatic logic signed [7:0] tgt_px(input logic [2:0] expr, input logic side,
		input logic [3:0] par);
		logic signed [7:0] v;
		v = base_px(side, par);
		case (expr)
			EXPR_SMILE: begin
				if (par == P_H)  v = 8'sd18;
				if (par == P_UA) v = 8'sd6;
				if (par == P_LA) v = -8'sd6;
			end
			EXPR_HAPPY: begin
				if (par == P_H)  v = 8'sd12;
				if (par == P_UA) v = 8'sd10;
				if (par == P_LA) v = -8'sd10;
			end
			EXPR_ANGRY: begin
				if (par == P_US) v = side ? -8'sd10 : 8'sd10;
				if (par == P_LS) v = side ? 8'sd10 : -8'sd10;
				if (par == P_H)  v = 8'sd26;
			end
			EXPR_SLEEPY: begin
				if (par == P_CY) v = 8'sd15;
				if (par == P_H)  v = 8'sd5;
				if (par == P_R)  v = 8'sd1;
				if (par == P_UA) v = 8'sd2;
			end
			EXPR_SURPRISE: begin
				if (par == P_W) v = 8'sd30;
				if (par == P_H) v = 8'sd42;
				if (par == P_R) v = 8'sd15;
			end
			EXPR_SAD: begin
				if (par == P_US) v = side ? 8'sd10 : -8'sd10;
				if (par == P_LS) v = side ? -8'sd8 : 8'sd8;
			end
			EXPR_CURIOUS: begin
				if (!side && par == P_H) v = 8'sd40;
				if (!side && par == P_W) v = 8'sd34;
				if (side && par == P_H)  v = 8'sd24;
			end
			default: v = base_px(side, par);
		endcase
		return v;
	endfunction

	// clamp to signed 16 bits
	function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
		logic signed [15:0] r;
		if (v > 40'sd32767)
			r = 16'sh7FFF;
		else if (v < -40'sd32768)
			r = 16'sh8000;
		else
			r = v[15:0];
		return r;
	endfunction

endpackage

// ----- rtl/eska_mul.sv -----
// ----------------------------------------------------------------------------
// eska_mul
// Shared registered signed multiplier for expression scaling and tweening.
// ----------------------------------------------------------------------------
module eska_mul (
	input  logic                clk,
	input  logic                en,
	input  logic signed [17:0]  a,
	input  logic signed [17:0]  b,
	output logic signed [35:0]  p
);
	logic signed [35:0] p_q;

	// product register, loaded on demand
	always_ff @(posedge clk) begin
		if (en)
			p_q <= a * b;
	end

	assign p = p_q;

endmodule

// ----- rtl/eye_shape_keyframe_animator.sv -----
// Eye shape keyframe animator: tweens two nine-value eye shapes toward keyframes.
// Request and unused commands give no beats; an idle tick with no new request goes from its
// accept cycle straight to its two beats. A playing tick passes accept, time update, the
// divider (one quotient bit a cycle) and 18 values through the shared multiplier before its
// two beats, a finished keyframe accept, time update and a copy of 18 values; a transition
// adds a keyframe fill. Actions fill 2 or 3 keyframes after accept, one item at a time.
// Reset is asynchronous: neutral shapes, no script, neutral expression at full amount.
module eye_shape_keyframe_animator #(
	parameter int FRAME_SLOTS = eska_pkg::FRAME_SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [1:0]         command,
	input  logic [9:0]         dt_ms,
	input  logic [2:0]         expression,
	input  logic [8:0]         amount,
	input  logic [1:0]         action,
	output logic               result_valid,
	input  logic               result_stall,
	output logic               eye_side,
	output logic signed [15:0] center_x,
	output logic signed [15:0] center_y,
	output logic signed [15:0] eye_width,
	output logic signed [15:0] eye_height,
	output logic signed [15:0] corner_radius,
	output logic signed [15:0] upper_arc,
	output logic signed [15:0] lower_arc,
	output logic signed [15:0] upper_slope,
	output logic signed [15:0] lower_slope,
	output logic               last
);
	import eska_pkg::*;

	localparam int SW    = $clog2(FRAME_SLOTS);
	localparam int DEPTH = FRAME_SLOTS * NELEM;
	localparam int AW    = $clog2(DEPTH);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_FILL = 3'd1;
	localparam logic [2:0] ST_TICK = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_MIX  = 3'd4;
	localparam logic [2:0] ST_COPY = 3'd5;
	localparam logic [2:0] ST_OUT0 = 3'd6;
	localparam logic [2:0] ST_OUT1 = 3'd7;

	logic [2:0]         state_q;
	logic [1:0]         ph_q;
	logic               side_q;
	logic [3:0]         par_q;
	logic [SW-1:0]      slot_q;
	logic [1:0]         kind_q;
	logic [1:0]         fcount_q;
	logic [1:0]         findex_q;
	logic [15:0]        elapsed_q;
	logic               playing_q;
	logic [2:0]         shown_e_q;
	logic [8:0]         shown_a_q;
	logic [2:0]         want_e_q;
	logic [8:0]         want_a_q;
	logic [9:0]         dt_q;
	logic [15:0]        t_q;
	logic [9:0]         rem_q;
	logic [3:0]         div_cnt_q;
	logic signed [15:0] cur_q   [NELEM];
	logic signed [15:0] start_q [NELEM];
	logic [9:0]         dur_q   [FRAME_SLOTS];
	logic signed [15:0] frame_mem [DEPTH];
	logic signed [15:0] rd_q;

	logic [4:0]         elem;
	logic [SW-1:0]      fidx;
	logic [9:0]         dur_cur;
	logic [AW-1:0]      raddr;
	logic [AW-1:0]      waddr;
	logic               begin_fill;
	logic [1:0]         begin_kind;
	logic [1:0]         begin_count;
	logic               same_expr;
	logic [8:0]         amt_diff;
	logic               src_cur;
	logic               lid;
	logic [2:0]         fe;
	logic [8:0]         fa;
	logic signed [7:0]  base_v;
	logic signed [8:0]  delta_v;
	logic signed [17:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [35:0] prod;
	logic signed [39:0] prod40;
	logic signed [39:0] fill_sum;
	logic signed [15:0] fill_val;
	logic signed [39:0] mix_sum;
	logic signed [15:0] mix_val;
	logic [16:0]        el_sum;
	logic [15:0]        el_sat;
	logic               kf_done;
	logic [10:0]        rem2;
	logic               rem_ge;
	logic               step_end;
	logic               elem_last;
	logic [1:0]         next_index;

	// element, slot and address decode
	assign elem    = 5'(par_q) + (side_q ? 5'(NPAR) : 5'd0);
	assign fidx    = (32'(findex_q) > FRAME_SLOTS - 1) ? SW'(FRAME_SLOTS - 1) : SW'(findex_q);
	assign dur_cur = dur_q[fidx];
	assign raddr   = AW'(32'(fidx) * NELEM + 32'(elem));
	assign waddr   = AW'(32'(slot_q) * NELEM + 32'(elem));

	assign step_end   = (ph_q == 2'd2);
	assign elem_last  = side_q && (par_q == P_LS);
	assign next_index = findex_q + 2'd1;

	// request compare against the shown expression
	assign amt_diff  = (shown_a_q > want_a_q) ? shown_a_q - want_a_q : want_a_q - shown_a_q;
	assign same_expr = (shown_e_q == want_e_q) && (amt_diff < AMT_TOL);

	// script start from an action beat or from an idle tick with a new request
	always_comb begin
		begin_fill  = 1'b0;
		begin_kind  = KIND_TRANS;
		begin_count = 2'd1;
		if (state_q == ST_IDLE && item_valid) begin
			if (command == CMD_ACTION && action != KIND_TRANS) begin
				begin_fill = 1'b1;
				begin_kind = action;
			end else if (command == CMD_TICK && !playing_q && !same_expr) begin
				begin_fill = 1'b1;
				begin_kind = KIND_TRANS;
			end
		end
		case (begin_kind)
			ACT_WAKE: begin_count = 2'd3;
			ACT_BLINK,
			ACT_SLEEP: begin_count = 2'd2;
			default: begin_count = 2'd1;
		endcase
	end

	// source of each keyframe slot during the fill
	always_comb begin
		src_cur = 1'b0;
		lid     = 1'b0;
		fe      = EXPR_SLEEPY;
		fa      = AMT_FULL;
		case (kind_q)
			ACT_BLINK: begin
				src_cur = 1'b1;
				lid     = (slot_q == '0);
			end
			ACT_WAKE: begin
				if (32'(slot_q) == 1)
					fe = EXPR_SURPRISE;
				else if (32'(slot_q) == 2) begin
					fe = want_e_q;
					fa = want_a_q;
				end
			end
			ACT_SLEEP: lid = (32'(slot_q) == 1);
			default: begin
				fe = want_e_q;
				fa = want_a_q;
			end
		endcase
	end

	// shared multiplier operands
	assign base_v  = base_px(side_q, par_q);
	assign delta_v = 9'(tgt_px(fe, side_q, par_q)) - 9'(base_v);

	always_comb begin
		if (state_q == ST_FILL) begin
			mul_a = 18'(delta_v);
			mul_b = $signed({9'd0, fa});
		end else begin
			mul_a = 18'(17'(rd_q) - 17'(start_q[elem]));
			mul_b = $signed({2'd0, t_q});
		end
	end

	eska_mul u_mul (
		.clk (clk),
		.en  (ph_q == 2'd1),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	assign prod40 = 40'(prod);

	// keyframe value: scaled expression, copied shape, closed lid
	always_comb begin
		fill_sum = (40'(base_v) <<< 8) + prod40;
		fill_val = sat16(fill_sum);
		if (src_cur)
			fill_val = cur_q[elem];
		if (lid && par_q == P_H)
			fill_val = LID_HEIGHT;
		if (lid && par_q == P_R)
			fill_val = LID_RADIUS;
	end

	// tween value, rounded half up
	assign mix_sum = 40'(start_q[elem]) + ((prod40 + 40'sd32768) >>> 16);
	assign mix_val = sat16(mix_sum);

	// elapsed time and keyframe completion
	assign el_sum  = {1'b0, elapsed_q} + 17'(dt_q);
	assign el_sat  = el_sum[16] ? 16'hFFFF : el_sum[15:0];
	assign kf_done = (dur_cur == 10'd0) || (el_sat >= 16'(dur_cur));

	// restoring divider step
	assign rem2   = {rem_q, 1'b0};
	assign rem_ge = rem2 >= 11'(dur_cur);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			ph_q      <= 2'd0;
			side_q    <= 1'b0;
			par_q     <= 4'd0;
			slot_q    <= '0;
			kind_q    <= ACT_BLINK;
			fcount_q  <= 2'd0;
			findex_q  <= 2'd0;
			elapsed_q <= 16'd0;
			playing_q <= 1'b0;
			shown_e_q <= EXPR_NEUTRAL;
			shown_a_q <= AMT_FULL;
			want_e_q  <= EXPR_NEUTRAL;
			want_a_q  <= AMT_FULL;
			div_cnt_q <= 4'd0;
		end else begin
			if (begin_fill) begin
				kind_q    <= begin_kind;
				fcount_q  <= begin_count;
				findex_q  <= 2'd0;
				elapsed_q <= 16'd0;
				playing_q <= 1'b1;
				slot_q    <= '0;
				state_q   <= ST_FILL;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						case (command)
							CMD_EXPR: begin
								want_e_q <= expression;
								want_a_q <= amount;
							end
							CMD_TICK: begin
								if (!playing_q) begin
									if (same_expr)
										state_q <= ST_OUT0;
									else begin
										shown_e_q <= want_e_q;
										shown_a_q <= want_a_q;
									end
								end else
									state_q <= ST_TICK;
							end
							default: ;
						endcase
					end
				end
				ST_FILL, ST_MIX, ST_COPY: begin
					if (step_end) begin
						ph_q <= 2'd0;
						if (elem_last) begin
							side_q <= 1'b0;
							par_q  <= 4'd0;
							if (state_q == ST_FILL) begin
								if (32'(slot_q) == 32'(fcount_q) - 1)
									state_q <= (kind_q == KIND_TRANS) ? ST_TICK : ST_IDLE;
								else
									slot_q <= slot_q + 1'b1;
							end else begin
								state_q <= ST_OUT0;
								if (state_q == ST_COPY) begin
									findex_q <= next_index;
									if (next_index >= fcount_q)
										playing_q <= 1'b0;
								end
							end
						end else if (par_q == P_LS) begin
							side_q <= 1'b1;
							par_q  <= 4'd0;
						end else
							par_q <= par_q + 4'd1;
					end else
						ph_q <= ph_q + 2'd1;
				end
				ST_TICK: begin
					div_cnt_q <= 4'd0;
					if (kf_done) begin
						elapsed_q <= 16'd0;
						state_q   <= ST_COPY;
					end else begin
						elapsed_q <= el_sat;
						state_q   <= ST_DIV;
					end
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + 4'd1;
					if (div_cnt_q == 4'd15)
						state_q <= ST_MIX;
				end
				ST_OUT0: begin
					if (!result_stall)
						state_q <= ST_OUT1;
				end
				ST_OUT1: begin
					if (!result_stall)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// tick payload and divider datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && item_valid)
			dt_q <= dt_ms;
		if (state_q == ST_TICK) begin
			rem_q <= el_sat[9:0];
			t_q   <= 16'd0;
		end else if (state_q == ST_DIV) begin
			rem_q <= rem_ge ? 10'(rem2 - 11'(dur_cur)) : rem2[9:0];
			t_q   <= {t_q[14:0], rem_ge};
		end
	end

	// keyframe durations per script
	always_ff @(posedge clk) begin
		if (begin_fill) begin
			case (begin_kind)
				ACT_BLINK: begin
					dur_q[0] <= DUR_BLINK0;
					dur_q[1] <= DUR_BLINK1;
				end
				ACT_WAKE: begin
					dur_q[0] <= DUR_WAKE0;
					dur_q[1] <= DUR_WAKE1;
					dur_q[2] <= DUR_WAKE2;
				end
				ACT_SLEEP: begin
					dur_q[0] <= DUR_SLEEP0;
					dur_q[1] <= DUR_SLEEP1;
				end
				default: dur_q[0] <= DUR_TRANS;
			endcase
		end
	end

	// keyframe shape memory, registered read
	always_ff @(posedge clk) begin
		if (state_q == ST_FILL && step_end)
			frame_mem[waddr] <= fill_val;
		rd_q <= frame_mem[raddr];
	end

	// current and start shapes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NELEM; j++) begin
				cur_q[j]   <= 16'(base_px(j >= NPAR, 4'(j >= NPAR ? j - NPAR : j))) <<< 8;
				start_q[j] <= 16'(base_px(j >= NPAR, 4'(j >= NPAR ? j - NPAR : j))) <<< 8;
			end
		end else begin
			if (begin_fill)
				for (int j = 0; j < NELEM; j++)
					start_q[j] <= cur_q[j];
			if (state_q == ST_MIX && step_end)
				cur_q[elem] <= mix_val;
			if (state_q == ST_COPY && step_end) begin
				cur_q[elem]   <= rd_q;
				start_q[elem] <= rd_q;
			end
		end
	end

	// handshake and result beats
	assign item_stall    = (state_q != ST_IDLE);
	assign result_valid  = (state_q == ST_OUT0) || (state_q == ST_OUT1);
	assign eye_side      = (state_q == ST_OUT1);
	assign last          = (state_q == ST_OUT1);
	assign center_x      = eye_side ? cur_q[NPAR + 0] : cur_q[0];
	assign center_y      = eye_side ? cur_q[NPAR + 1] : cur_q[1];
	assign eye_width     = eye_side ? cur_q[NPAR + 2] : cur_q[2];
	assign eye_height    = eye_side ? cur_q[NPAR + 3] : cur_q[3];
	assign corner_radius = eye_side ? cur_q[NPAR + 4] : cur_q[4];
	assign upper_arc     = eye_side ? cur_q[NPAR + 5] : cur_q[5];
	assign lower_arc     = eye_side ? cur_q[NPAR + 6] : cur_q[6];
	assign upper_slope   = eye_side ? cur_q[NPAR + 7] : cur_q[7];
	assign lower_slope   = eye_side ? cur_q[NPAR + 8] : cur_q[8];

	// no input beat taken while a result is shown
	a_stall_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> item_stall)
		else $error("input accepted while a result beat is pending");

	// a tick ends after its right eye beat
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_stall && last) |=> !result_valid)
		else $error("result beat after the last beat of a tick");

	// divider remainder stays below the duration
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < dur_cur))
		else $error("divider remainder out of range");

endmodule
